>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> src/ftr_pkg.sv
// shared types and constants of the triangle rasterizer
`timescale 1ns / 1ps
package ftr_pkg;
	localparam int FRAC_BITS = 6;
	localparam logic [5:0] FRAC_MASK = 6'h3f;
	localparam logic [5:0] HALF_MASK = 6'h1f;
	localparam int FX_W = 20;
	localparam int DIV_STEPS = 16;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_READ_WAIT, ST_SORT, ST_DIV, ST_DIV_WAIT, ST_SETUP,
		ST_SPAN, ST_PIXEL, ST_SETUP2, ST_DONE
	} ftr_state_t;

	typedef enum logic [1:0] {
		SEG_TOP, SEG_BOTTOM
	} ftr_seg_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic read_issue;
		logic sort;
		logic div_start;
		logic setup1;
		logic setup2;
		logic span_start;
		logic pixel_step;
		logic row_step;
	} ftr_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_read;
		logic div_done;
		logic top_rows_left;
		logic bottom_rows_left;
		logic span_pixels_left;
	} ftr_stat_t;
endpackage

>>> src/flat_triangle_rasterizer.sv
// top level of the flat triangle rasterizer
`timescale 1ns / 1ps
// Usage: drive the word's fields and raise start while busy is low; the word
// is taken at that edge. operation 0 draws a filled triangle into the frame
// store, operation 1 reads one pixel back. Every word yields one result word,
// shown on read_data and was_read for one cycle while strobe is high.
// A read passes from the sort state through the read and read wait states. A draw
// runs the three slope divisions on the shared 16 step divider (an edge with no row
// difference gets a zero slope without it), then walks the rows and writes each
// pixel through the single frame store port.
// Reset clears the controller; the frame store holds no reset value and a
// pixel must be drawn before it is read. The receiver cannot stall: the
// result is shown once and must be taken in that cycle.
module flat_triangle_rasterizer #(
	parameter int SCREEN_WIDTH = 320,
	parameter int SCREEN_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       strobe,
	input  logic       operation,
	input  logic [8:0] ax,
	input  logic [7:0] ay,
	input  logic [8:0] bx,
	input  logic [7:0] by,
	input  logic [8:0] cx,
	input  logic [7:0] cy,
	input  logic [7:0] fill_colour,
	input  logic [8:0] read_x,
	input  logic [7:0] read_y,
	output logic [7:0] read_data,
	output logic       was_read
);
	import ftr_pkg::*;

	ftr_cmd_t  cmd;
	ftr_stat_t stat;

	ftr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.strobe(strobe), .cmd(cmd), .stat(stat)
	);

	ftr_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.operation(operation), .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
		.fill_colour(fill_colour), .read_x(read_x), .read_y(read_y),
		.read_data(read_data), .was_read(was_read)
	);
endmodule

>>> src/ftr_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module ftr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one word when we is set, and read one word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> src/ftr_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
module ftr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [ftr_pkg::FX_W-1:0] num,
	input  logic signed [9:0]            den,
	output logic                         done,
	output logic signed [ftr_pkg::FX_W-1:0] quo
);
	import ftr_pkg::*;

	logic [15:0] n_q;
	logic [15:0] q_q;
	logic [9:0]  rem_q;
	logic [8:0]  d_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [9:0]  trial;
	logic [10:0] diff;

	// restoring step
	always_comb begin
		trial = {rem_q[8:0], n_q[15]};
		diff = {1'b0, trial} - {2'b00, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// datapath of the divider
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num[FX_W-1] ? 16'(-num) : 16'(num);
			d_q <= den[9] ? 9'(-den) : 9'(den);
			neg_q <= num[FX_W-1] ^ den[9];
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[14:0], 1'b0};
			if (!diff[10]) begin
				rem_q <= diff[9:0];
				q_q <= {q_q[14:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[14:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -FX_W'(signed'({1'b0, q_q})) : FX_W'(signed'({1'b0, q_q}));
endmodule

>>> src/ftr_ctrl.sv
// controller state machine of the triangle rasterizer
`timescale 1ns / 1ps
module ftr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              strobe,
	output ftr_pkg::ftr_cmd_t cmd,
	input  ftr_pkg::ftr_stat_t stat
);
	import ftr_pkg::*;

	ftr_state_t state_q, state_d;
	logic [1:0] div_cnt_q;
	logic       strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_cnt_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= (state_q == ST_READ_WAIT) || (state_q == ST_DONE);
			if (state_q == ST_SORT) div_cnt_q <= '0;
			else if ((state_q == ST_DIV || state_q == ST_DIV_WAIT) && stat.div_done)
				div_cnt_q <= div_cnt_q + 2'd1;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign strobe = strobe_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				if (stat.is_read) begin
					cmd.read_issue = 1'b1;
					state_d = ST_READ;
				end else begin
					cmd.sort = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_READ: state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_IDLE;
			ST_DIV: begin
				cmd.div_start = 1'b1;
				// a zero row difference gives a zero slope at once
				if (stat.div_done) begin
					state_d = (div_cnt_q == 2'd2) ? ST_SETUP : ST_DIV;
				end else begin
					state_d = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = (div_cnt_q == 2'd2) ? ST_SETUP : ST_DIV;
				end
			end
			ST_SETUP: begin
				cmd.setup1 = 1'b1;
				state_d = ST_SPAN;
			end
			ST_SPAN: begin
				if (stat.top_rows_left || stat.bottom_rows_left) begin
					cmd.span_start = 1'b1;
					state_d = ST_PIXEL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PIXEL: begin
				if (stat.span_pixels_left) begin
					cmd.pixel_step = 1'b1;
				end else begin
					cmd.row_step = 1'b1;
					state_d = ST_SETUP2;
				end
			end
			ST_SETUP2: begin
				cmd.setup2 = 1'b1;
				state_d = ST_SPAN;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> src/ftr_dp.sv
// datapath: vertex sort, slopes, span walk and frame store
`timescale 1ns / 1ps
module ftr_dp #(
	parameter int SCREEN_WIDTH = 320,
	parameter int SCREEN_HEIGHT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ftr_pkg::ftr_cmd_t  cmd,
	output ftr_pkg::ftr_stat_t stat,
	input  logic               operation,
	input  logic [8:0]         ax,
	input  logic [7:0]         ay,
	input  logic [8:0]         bx,
	input  logic [7:0]         by,
	input  logic [8:0]         cx,
	input  logic [7:0]         cy,
	input  logic [7:0]         fill_colour,
	input  logic [8:0]         read_x,
	input  logic [7:0]         read_y,
	output logic [7:0]         read_data,
	output logic               was_read
);
	import ftr_pkg::*;

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	logic              op_q;
	logic [8:0]        x1_q, x2_q, x3_q, rx_q;
	logic [7:0]        y1_q, y2_q, y3_q, ry_q, col_q;
	logic signed [FX_W-1:0] s12_q, s13_q, s23_q, sl_q, sr_q, left_q, right_q;
	logic              swapped_q, seg_q, rd_ok_q;
	logic [8:0]        row_q;
	logic signed [FX_W-1:0] px_q, hi_q;
	logic [1:0]        div_idx_q;
	logic              div_done;
	logic signed [FX_W-1:0] div_num, div_quo;
	logic signed [9:0] div_den;
	logic              we;
	logic [AW-1:0]     addr;
	logic [7:0]        rdata;
	logic [AW-1:0]     row_base;
	logic signed [FX_W-1:0] lo_c, hi_c;
	logic [8:0]        s_x1, s_x2, s_x3;
	logic [7:0]        s_y1, s_y2, s_y3;
	logic [8:0]        tx;
	logic [7:0]        ty;

	// divider operand choice per slope
	always_comb begin
		unique case (div_idx_q)
			2'd0: begin
				div_num = FX_W'(signed'({1'b0, x2_q})) - FX_W'(signed'({1'b0, x1_q}));
				div_den = 10'(signed'({2'b0, y2_q})) - 10'(signed'({2'b0, y1_q}));
			end
			2'd1: begin
				div_num = FX_W'(signed'({1'b0, x3_q})) - FX_W'(signed'({1'b0, x1_q}));
				div_den = 10'(signed'({2'b0, y3_q})) - 10'(signed'({2'b0, y1_q}));
			end
			default: begin
				div_num = FX_W'(signed'({1'b0, x3_q})) - FX_W'(signed'({1'b0, x2_q}));
				div_den = 10'(signed'({2'b0, y3_q})) - 10'(signed'({2'b0, y2_q}));
			end
		endcase
		div_num = div_num <<< FRAC_BITS;
	end

	ftr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start && div_den != '0),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// three compare and swap steps, swap on strictly greater
	always_comb begin
		s_x1 = x1_q; s_y1 = y1_q; s_x2 = x2_q; s_y2 = y2_q; s_x3 = x3_q; s_y3 = y3_q;
		if (s_y2 > s_y3) begin
			tx = s_x2; s_x2 = s_x3; s_x3 = tx; ty = s_y2; s_y2 = s_y3; s_y3 = ty;
		end
		if (s_y1 > s_y2) begin
			tx = s_x1; s_x1 = s_x2; s_x2 = tx; ty = s_y1; s_y1 = s_y2; s_y2 = ty;
		end
		if (s_y2 > s_y3) begin
			tx = s_x2; s_x2 = s_x3; s_x3 = tx; ty = s_y2; s_y2 = s_y3; s_y3 = ty;
		end
		tx = '0; ty = '0;
	end

	// span ends: left floored and clamped at zero, right rounded up from half and clamped at the screen width
	always_comb begin
		lo_c = left_q >>> FRAC_BITS;
		hi_c = right_q >>> FRAC_BITS;
		if (right_q[5:0] > HALF_MASK) hi_c = hi_c + FX_W'(1);
		if (lo_c < 0) lo_c = '0;
		if (hi_c > FX_W'(SCREEN_WIDTH)) hi_c = FX_W'(SCREEN_WIDTH);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_idx_q <= '0;
			seg_q <= 1'b0;
			was_read <= 1'b0;
		end else begin
			if (cmd.sort) div_idx_q <= '0;
			else if (div_done || (cmd.div_start && div_den == '0)) div_idx_q <= div_idx_q + 2'd1;
			if (cmd.setup1) seg_q <= (y1_q >= y2_q);
			else if (cmd.setup2 && !seg_q && row_q == {1'b0, y2_q}) seg_q <= 1'b1;
			if (cmd.read_issue) was_read <= 1'b1;
			else if (cmd.setup1) was_read <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			x1_q <= ax; y1_q <= ay; x2_q <= bx; y2_q <= by; x3_q <= cx; y3_q <= cy;
			col_q <= fill_colour; rx_q <= read_x; ry_q <= read_y;
		end
		if (cmd.read_issue) rd_ok_q <= (32'(rx_q) < SCREEN_WIDTH) && (32'(ry_q) < SCREEN_HEIGHT);
		if (cmd.sort) begin
			x1_q <= s_x1; y1_q <= s_y1; x2_q <= s_x2; y2_q <= s_y2; x3_q <= s_x3; y3_q <= s_y3;
		end
		if (cmd.div_start && div_den == '0 || div_done) begin
			unique case (div_idx_q)
				2'd0: s12_q <= (div_den == '0) ? '0 : div_quo;
				2'd1: s13_q <= (div_den == '0) ? '0 : div_quo;
				default: s23_q <= (div_den == '0) ? '0 : div_quo;
			endcase
		end
		if (cmd.setup1) begin
			row_q <= {1'b0, y1_q};
			swapped_q <= (s13_q < s12_q);
			if (y1_q == y2_q) begin
				// flat top: ends start at the two top vertices
				if (s13_q < s23_q) begin
					sl_q <= s23_q; sr_q <= s13_q;
					left_q <= FX_W'(signed'({1'b0, x2_q})) <<< FRAC_BITS;
					right_q <= FX_W'(signed'({1'b0, x1_q})) <<< FRAC_BITS;
				end else begin
					sl_q <= s13_q; sr_q <= s23_q;
					left_q <= FX_W'(signed'({1'b0, x1_q})) <<< FRAC_BITS;
					right_q <= FX_W'(signed'({1'b0, x2_q})) <<< FRAC_BITS;
				end
			end else begin
				left_q <= FX_W'(signed'({1'b0, x1_q})) <<< FRAC_BITS;
				right_q <= FX_W'(signed'({1'b0, x1_q})) <<< FRAC_BITS;
				if (s13_q < s12_q) begin
					sl_q <= s13_q; sr_q <= s12_q;
				end else begin
					sl_q <= s12_q; sr_q <= s13_q;
				end
			end
		end
		if (cmd.span_start) begin
			px_q <= lo_c;
			hi_q <= hi_c;
		end
		if (cmd.pixel_step) px_q <= px_q + FX_W'(1);
		if (cmd.row_step) begin
			left_q <= left_q + sl_q;
			right_q <= right_q + sr_q;
			row_q <= row_q + 9'd1;
		end
		// switch to the lower part's slopes on entering row y2
		if (cmd.setup2 && !seg_q && row_q == {1'b0, y2_q}) begin
			if ((swapped_q ? sl_q : sr_q) < s23_q) begin
				sl_q <= s23_q;
				sr_q <= swapped_q ? sl_q : sr_q;
			end else begin
				sl_q <= swapped_q ? sl_q : sr_q;
				sr_q <= s23_q;
			end
		end
	end

	assign row_base = AW'(row_q[7:0]) * AW'(SCREEN_WIDTH);
	assign we = cmd.pixel_step && (32'(row_q) < SCREEN_HEIGHT) && !op_q;
	// a read keeps its address until the next word so the pixel stays on rdata
	assign addr = op_q ? AW'(AW'(ry_q) * AW'(SCREEN_WIDTH) + AW'(rx_q))
	                   : AW'(row_base + AW'(px_q[8:0]));

	ftr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(col_q),
		.rdata(rdata)
	);

	assign read_data = (was_read && rd_ok_q) ? rdata : 8'd0;

	// status toward the controller
	always_comb begin
		stat.is_read = op_q;
		stat.div_done = div_done || (cmd.div_start && div_den == '0);
		stat.top_rows_left = !seg_q && (row_q < {1'b0, y2_q});
		stat.bottom_rows_left = (row_q <= {1'b0, y3_q});
		stat.span_pixels_left = (px_q < hi_q);
	end
endmodule

>>> src/ftr_checker.sv
// port level checks of the rasterizer and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ftr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic was_read,
	input logic [7:0] read_data
);
	`ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_strobe_single, clk, arst_n, strobe, !strobe)
	`ASSERT_IMPL(a_strobe_idle, clk, arst_n, strobe, !busy)
	`ASSERT_IMPL(a_draw_zero, clk, arst_n, strobe && !was_read, read_data == 8'd0)
endmodule

bind flat_triangle_rasterizer ftr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.strobe(strobe), .was_read(was_read), .read_data(read_data)
);

>>> test/tb_flat_triangle_rasterizer.sv
// self-checking testbench for the flat triangle rasterizer
`timescale 1ns / 1ps
module tb_flat_triangle_rasterizer;
	localparam int SCR_W = 320;
	localparam int SCR_H = 256;
	localparam int FB = 6;
	localparam int N_RANDOM = 530;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct {
		logic       op;
		logic [8:0] ax, bx, cx, rx;
		logic [7:0] ay, by, cy, colour, ry;
	} word_t;

	typedef struct {
		logic [7:0] data;
		logic       rd;
	} answer_t;

	logic clk, arst_n, start, busy, strobe, operation, was_read;
	logic [8:0] ax, bx, cx, read_x;
	logic [7:0] ay, by, cy, fill_colour, read_y, read_data;

	flat_triangle_rasterizer i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
		.operation(operation), .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
		.fill_colour(fill_colour), .read_x(read_x), .read_y(read_y),
		.read_data(read_data), .was_read(was_read)
	);

	word_t   pending_words[$];
	answer_t expected_answers[$];
	logic [7:0] pixel_mem [SCR_W*SCR_H];
	bit      painted [SCR_W*SCR_H];
	int      painted_idx[$];
	int      errors = 0;
	int      draws_done = 0, reads_done = 0, answers_seen = 0;
	bit      taken = 0;
	bit      gen_done = 0;
	int      idle_left = 0;
	longint  cycles = 0;

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// fixed point slope, truncating toward zero
	function automatic int edge_step(int xa, int ya, int xb, int yb);
		if (ya == yb)
			return 0;
		return ((xb - xa) * (1 << FB)) / (yb - ya);
	endfunction

	// one span: commit writes pixels, otherwise only marks coverage
	function automatic void span(int row, int l, int r, logic [7:0] c, bit commit);
		int lo, hi, idx;
		lo = l >>> FB;
		hi = (r >>> FB) + (((r & 63) > 31) ? 1 : 0);
		if (row < 0 || row >= SCR_H)
			return;
		if (lo < 0)
			lo = 0;
		if (hi > SCR_W)
			hi = SCR_W;
		for (int x = lo; x < hi; x++) begin
			idx = row * SCR_W + x;
			if (commit)
				pixel_mem[idx] = c;
			else if (!painted[idx]) begin
				painted[idx] = 1;
				painted_idx.push_back(idx);
			end
		end
	endfunction

	function automatic void rasterize(word_t w, bit commit);
		int x1, y1, x2, y2, x3, y3, t, s12, s13, s23, sl, sr, l, r;
		bit swapped;
		x1 = w.ax; y1 = w.ay; x2 = w.bx; y2 = w.by; x3 = w.cx; y3 = w.cy;
		swapped = 0;
		// three compare-and-swap steps on y
		if (y2 > y3) begin t = x2; x2 = x3; x3 = t; t = y2; y2 = y3; y3 = t; end
		if (y1 > y2) begin t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t; end
		if (y2 > y3) begin t = x2; x2 = x3; x3 = t; t = y2; y2 = y3; y3 = t; end
		s12 = edge_step(x1, y1, x2, y2);
		s13 = edge_step(x1, y1, x3, y3);
		s23 = edge_step(x2, y2, x3, y3);
		l = x1 << FB;
		r = l;
		sl = s12;
		sr = s13;
		if (sr < sl) begin t = sl; sl = sr; sr = t; swapped = 1; end
		// upper part
		for (int y = y1; y < y2; y++) begin
			span(y, l, r, w.colour, commit);
			l += sl;
			r += sr;
		end
		if (swapped) begin t = sl; sl = sr; sr = t; end
		if (sr < s23) begin
			sl = s23;
			if (y1 == y2) begin
				l = x2 << FB;
				r = x1 << FB;
			end
		end else begin
			sl = sr;
			sr = s23;
			if (y1 == y2) begin
				l = x1 << FB;
				r = x2 << FB;
			end
		end
		// lower part
		for (int y = y2; y <= y3; y++) begin
			span(y, l, r, w.colour, commit);
			l += sl;
			r += sr;
		end
	endfunction

	function automatic word_t make_draw(int x1, int y1, int x2, int y2, int x3, int y3, int c);
		word_t w;
		w.op = OP_DRAW;
		w.ax = x1; w.ay = y1; w.bx = x2; w.by = y2; w.cx = x3; w.cy = y3;
		w.colour = c;
		w.rx = $urandom_range(511);
		w.ry = $urandom_range(255);
		return w;
	endfunction

	// read of a covered pixel, or of a column past the screen edge
	function automatic word_t make_read(bit off_screen);
		word_t w;
		int idx;
		w = make_draw($urandom_range(511), $urandom_range(255), $urandom_range(511),
			$urandom_range(255), $urandom_range(511), $urandom_range(255),
			$urandom_range(255));
		w.op = OP_READ;
		if (off_screen || painted_idx.size() == 0) begin
			w.rx = $urandom_range(511, SCR_W);
			w.ry = $urandom_range(255);
		end else begin
			idx = painted_idx[$urandom_range(painted_idx.size() - 1)];
			w.rx = idx % SCR_W;
			w.ry = idx / SCR_W;
		end
		return w;
	endfunction

	function automatic int clampi(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	task automatic queue_word(word_t w);
		if (w.op == OP_DRAW)
			rasterize(w, 0);
		pending_words.push_back(w);
	endtask

	// stimulus
	initial begin
		int bx0, by0, sz;
		// directed part
		queue_word(make_draw(0, 0, 319, 0, 0, 255, 8'hff));
		queue_word(make_read(0));
		queue_word(make_draw(319, 255, 0, 255, 319, 0, 8'h00));
		queue_word(make_read(0));
		queue_word(make_draw(10, 20, 60, 20, 30, 50, 8'h5a));
		queue_word(make_draw(30, 100, 5, 140, 70, 140, 8'ha5));
		queue_word(make_draw(100, 60, 140, 90, 120, 30, 8'h3c));
		queue_word(make_draw(200, 10, 220, 30, 240, 50, 8'h11));
		queue_word(make_draw(150, 200, 190, 200, 170, 200, 8'h22));
		queue_word(make_draw(250, 250, 250, 250, 250, 250, 8'h33));
		queue_word(make_draw(300, 0, 319, 255, 280, 128, 8'h44));
		queue_word(make_draw(319, 5, 0, 9, 160, 7, 8'hc3));
		queue_word(make_read(1));
		queue_word(make_read(1));
		for (int i = 0; i < 6; i++)
			queue_word(make_read(0));
		// random part: reads and draws; the draws are mostly small triangles, a few large ones
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(99) < 45) begin
				sz = ($urandom_range(99) < 3) ? 255 : $urandom_range(24);
				bx0 = $urandom_range(SCR_W - 1);
				by0 = $urandom_range(SCR_H - 1);
				queue_word(make_draw(
					clampi(bx0 + $urandom_range(2*sz) - sz, 0, SCR_W - 1),
					clampi(by0 + $urandom_range(2*sz) - sz, 0, SCR_H - 1),
					clampi(bx0 + $urandom_range(2*sz) - sz, 0, SCR_W - 1),
					clampi(by0 + $urandom_range(2*sz) - sz, 0, SCR_H - 1),
					clampi(bx0 + $urandom_range(2*sz) - sz, 0, SCR_W - 1),
					clampi(by0 + $urandom_range(2*sz) - sz, 0, SCR_H - 1),
					$urandom_range(255)));
			end else
				queue_word(make_read($urandom_range(99) < 5));
		end
		gen_done = 1;
	end

	// reset and inputs from time zero
	initial begin
		arst_n = 0;
		start = 0;
		operation = 0;
		ax = 0; ay = 0; bx = 0; by = 0; cx = 0; cy = 0;
		fill_colour = 0; read_x = 0; read_y = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// driver: new word or idle burst at the falling edge
	always @(negedge clk) begin
		if (arst_n && gen_done && !(start && !taken)) begin
			taken = 0;
			if (idle_left > 0) begin
				idle_left--;
				start <= 0;
			end else if (pending_words.size() > 0) begin
				if (pending_words.size() > 60 && $urandom_range(99) < 20) begin
					idle_left = $urandom_range(16);
					start <= 0;
				end else begin
					operation <= pending_words[0].op;
					ax <= pending_words[0].ax; ay <= pending_words[0].ay;
					bx <= pending_words[0].bx; by <= pending_words[0].by;
					cx <= pending_words[0].cx; cy <= pending_words[0].cy;
					fill_colour <= pending_words[0].colour;
					read_x <= pending_words[0].rx; read_y <= pending_words[0].ry;
					start <= 1;
					void'(pending_words.pop_front());
				end
			end else
				start <= 0;
		end
	end

	// acceptance, prediction and result check at the rising edge
	always @(posedge clk) begin
		word_t w;
		answer_t a;
		if (arst_n) begin
			if (strobe) begin
				answers_seen++;
				if (expected_answers.size() == 0) begin
					errors++;
					$display("unexpected result word at %0t", $realtime);
				end else begin
					a = expected_answers.pop_front();
					if (was_read !== a.rd)
						report("was_read", was_read, a.rd);
					if (read_data !== a.data)
						report("read_data", read_data, a.data);
				end
			end
			if (start && !busy && !taken) begin
				taken = 1;
				w.op = operation; w.ax = ax; w.ay = ay; w.bx = bx; w.by = by;
				w.cx = cx; w.cy = cy; w.colour = fill_colour; w.rx = read_x; w.ry = read_y;
				if (w.op == OP_DRAW) begin
					rasterize(w, 1);
					a.data = 0;
					a.rd = 0;
					draws_done++;
				end else begin
					a.rd = 1;
					a.data = (w.rx < SCR_W && w.ry < SCR_H) ?
						pixel_mem[w.ry * SCR_W + w.rx] : 8'h00;
					reads_done++;
				end
				expected_answers.push_back(a);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (gen_done);
		@(posedge clk);
		while (pending_words.size() > 0 || (start && !taken) || expected_answers.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d draws and %0d reads, %0d result words checked",
			draws_done, reads_done, answers_seen);
		$display("%0d pixels were covered at least once", painted_idx.size());
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
